// ===== design/ihex_pkg.sv =====
// Shared types and codes for the Intel HEX record parser.
// This package depends on nothing. The front, back and top level files use it.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

	// Result kinds.
	localparam logic [2:0] KIND_DATA  = 3'd0;
	localparam logic [2:0] KIND_DONE  = 3'd1;
	localparam logic [2:0] KIND_EOF   = 3'd2;
	localparam logic [2:0] KIND_BASE  = 3'd3;
	localparam logic [2:0] KIND_START = 3'd4;
	localparam logic [2:0] KIND_ERROR = 3'd5;

	// Error codes.
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_HEX     = 3'd1;
	localparam logic [2:0] ERR_LONG    = 3'd2;
	localparam logic [2:0] ERR_EOF_SUM = 3'd3;
	localparam logic [2:0] ERR_SEGMENT = 3'd4;

	// Record types.
	localparam logic [7:0] REC_DATA    = 8'h00;
	localparam logic [7:0] REC_EOF     = 8'h01;
	localparam logic [7:0] REC_ESA     = 8'h02;
	localparam logic [7:0] REC_SSA     = 8'h03;
	localparam logic [7:0] REC_ELA     = 8'h04;
	localparam logic [7:0] REC_SLA     = 8'h05;

	localparam logic [7:0] CHAR_COLON  = 8'h3a;
	localparam logic [7:0] EOF_SUM     = 8'hff;

	// One classified character.
	typedef struct packed {
		logic       colon;
		logic       hex;
		logic [3:0] nibble;
	} tok_t;

	// One result word.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [31:0] effective_address;
		logic [15:0] record_address;
		logic [7:0]  record_length;
		logic [7:0]  record_type;
		logic [31:0] current_base;
		logic [31:0] entry_address;
		logic [2:0]  error_code;
	} res_t;

endpackage

`default_nettype wire

// ===== design/ihex_front.sv =====
// Front end: classifies each received character and holds it in a two-entry queue.
// Uses ihex_pkg for the token type.
`timescale 1ns / 1ps
`default_nettype none

module ihex_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output      logic          full,
	input  wire logic [7:0]    character,
	output      logic          tok_valid,
	input  wire logic          tok_ready,
	output      ihex_pkg::tok_t tok
);

	ihex_pkg::tok_t tok_in;
	ihex_pkg::tok_t queue_q [2];
	logic [1:0]     count_q;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic           do_push;
	logic           do_pop;

	// Hex digit decode: digits, upper and lower case A through F.
	always_comb begin
		tok_in.colon  = (character == ihex_pkg::CHAR_COLON);
		tok_in.hex    = 1'b0;
		tok_in.nibble = 4'd0;
		if (character >= 8'h30 && character <= 8'h39) begin
			tok_in.hex    = 1'b1;
			tok_in.nibble = character[3:0];
		end else if ((character >= 8'h41 && character <= 8'h46) ||
				(character >= 8'h61 && character <= 8'h66)) begin
			tok_in.hex    = 1'b1;
			tok_in.nibble = character[3:0] + 4'd9;
		end
	end

	assign full      = (count_q == 2'd2);
	assign tok_valid = (count_q != 2'd0);
	assign tok       = queue_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = tok_valid && tok_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= tok_in;
		end
	end

endmodule

`default_nettype wire

// ===== design/ihex_back.sv =====
// Back end: record state machine that turns tokens into result words,
// with a two-entry result queue. Uses ihex_pkg for token, result and codes.
`timescale 1ns / 1ps
`default_nettype none

module ihex_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_write,
	input  wire logic [7:0]     cfg_data,
	input  wire logic           tok_valid,
	output      logic           tok_ready,
	input  wire ihex_pkg::tok_t tok,
	output      logic           empty,
	input  wire logic           pop,
	output      ihex_pkg::res_t res
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_ADDR,
		PH_TYPE,
		PH_DATA,
		PH_ELA,
		PH_SLA,
		PH_CSUM
	} phase_t;

	phase_t         phase_q, phase_d;
	logic [2:0]     digit_q, digit_d;
	logic [31:0]    acc_q, acc_d;
	logic [7:0]     len_q, len_d;
	logic [15:0]    addr_q, addr_d;
	logic [7:0]     type_q, type_d;
	logic [7:0]     index_q, index_d;
	logic [31:0]    base_q, base_d;
	logic [31:0]    start_q, start_d;
	logic [31:0]    rec_base_q, rec_base_d;   // base plus record address
	logic [7:0]     limit_q;

	logic [31:0]    acc_n;
	logic [2:0]     last_digit;
	logic           emit;
	logic [2:0]     kind;
	logic [2:0]     err;
	logic [7:0]     data;
	logic [31:0]    eff;
	logic           take;

	ihex_pkg::res_t queue_q [2];
	ihex_pkg::res_t res_in;
	logic [1:0]     count_q;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic           do_pop;
	logic           do_push;

	assign do_pop    = pop && !empty;
	assign tok_ready = (count_q != 2'd2) || do_pop;
	assign take      = tok_valid && tok_ready;
	assign acc_n     = {acc_q[27:0], tok.nibble};

	always_comb begin
		unique case (phase_q)
			PH_ADDR, PH_ELA: last_digit = 3'd3;
			PH_SLA:          last_digit = 3'd7;
			default:         last_digit = 3'd1;
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		digit_d    = digit_q;
		acc_d      = acc_q;
		len_d      = len_q;
		addr_d     = addr_q;
		type_d     = type_q;
		index_d    = index_q;
		base_d     = base_q;
		start_d    = start_q;
		rec_base_d = rec_base_q;
		emit       = 1'b0;
		kind       = ihex_pkg::KIND_ERROR;
		err        = ihex_pkg::ERR_NONE;
		data       = 8'd0;
		eff        = rec_base_q;
		if (phase_q == PH_HUNT) begin
			if (tok.colon) begin
				phase_d = PH_LEN;
				digit_d = 3'd0;
				acc_d   = 32'd0;
			end
		end else if (!tok.hex) begin
			phase_d = PH_HUNT;
			digit_d = 3'd0;
			acc_d   = 32'd0;
			emit    = 1'b1;
			err     = ihex_pkg::ERR_HEX;
		end else if (digit_q != last_digit) begin
			digit_d = digit_q + 3'd1;
			acc_d   = acc_n;
		end else begin
			digit_d = 3'd0;
			acc_d   = 32'd0;
			unique case (phase_q)
				PH_LEN: begin
					len_d   = acc_n[7:0];
					phase_d = PH_ADDR;
				end
				PH_ADDR: begin
					addr_d     = acc_n[15:0];
					rec_base_d = base_q + {16'd0, acc_n[15:0]};
					phase_d    = PH_TYPE;
				end
				PH_TYPE: begin
					type_d  = acc_n[7:0];
					index_d = 8'd0;
					unique case (acc_n[7:0])
						ihex_pkg::REC_DATA: begin
							if (len_q > limit_q) begin
								phase_d = PH_HUNT;
								emit    = 1'b1;
								err     = ihex_pkg::ERR_LONG;
							end else begin
								phase_d = (len_q != 8'd0) ? PH_DATA : PH_CSUM;
							end
						end
						ihex_pkg::REC_EOF: phase_d = PH_CSUM;
						ihex_pkg::REC_ESA, ihex_pkg::REC_SSA: begin
							phase_d = PH_HUNT;
							emit    = 1'b1;
							err     = ihex_pkg::ERR_SEGMENT;
						end
						ihex_pkg::REC_ELA: phase_d = PH_ELA;
						ihex_pkg::REC_SLA: phase_d = PH_SLA;
						default:           phase_d = PH_HUNT;
					endcase
				end
				PH_DATA: begin
					index_d = index_q + 8'd1;
					if (index_q + 8'd1 == len_q) begin
						phase_d = PH_CSUM;
					end
					emit = 1'b1;
					kind = ihex_pkg::KIND_DATA;
					data = acc_n[7:0];
					eff  = rec_base_q + {24'd0, index_q};
				end
				PH_ELA: begin
					base_d     = {acc_n[15:0], 16'd0};
					rec_base_d = {acc_n[15:0], 16'd0} + {16'd0, addr_q};
					phase_d    = PH_CSUM;
				end
				PH_SLA: begin
					start_d = acc_n;
					phase_d = PH_CSUM;
				end
				default: begin
					// Checksum field closes the record.
					phase_d = PH_HUNT;
					emit    = 1'b1;
					unique case (type_q)
						ihex_pkg::REC_DATA: kind = ihex_pkg::KIND_DONE;
						ihex_pkg::REC_EOF: begin
							if (acc_n[7:0] == ihex_pkg::EOF_SUM) begin
								kind = ihex_pkg::KIND_EOF;
							end else begin
								err = ihex_pkg::ERR_EOF_SUM;
							end
						end
						ihex_pkg::REC_ELA: kind = ihex_pkg::KIND_BASE;
						default:           kind = ihex_pkg::KIND_START;
					endcase
				end
			endcase
		end
	end

	always_comb begin
		res_in.kind              = kind;
		res_in.data_byte         = data;
		res_in.effective_address = eff;
		res_in.record_address    = addr_d;
		res_in.record_length     = len_d;
		res_in.record_type       = type_d;
		res_in.current_base      = base_d;
		res_in.entry_address     = start_d;
		res_in.error_code        = err;
	end

	assign do_push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			digit_q    <= 3'd0;
			acc_q      <= 32'd0;
			len_q      <= 8'd0;
			addr_q     <= 16'd0;
			type_q     <= 8'd0;
			index_q    <= 8'd0;
			base_q     <= 32'd0;
			start_q    <= 32'd0;
			rec_base_q <= 32'd0;
			limit_q    <= 8'hff;
		end else begin
			if (cfg_write) begin
				limit_q <= cfg_data;
			end
			if (take) begin
				phase_q    <= phase_d;
				digit_q    <= digit_d;
				acc_q      <= acc_d;
				len_q      <= len_d;
				addr_q     <= addr_d;
				type_q     <= type_d;
				index_q    <= index_d;
				base_q     <= base_d;
				start_q    <= start_d;
				rec_base_q <= rec_base_d;
			end
		end
	end

	// Result queue.
	assign empty = (count_q == 2'd0);
	assign res   = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= res_in;
		end
	end

endmodule

`default_nettype wire

// ===== design/intel_hex_record_parser.sv =====
// Top level of the Intel HEX record parser: a character front end, a record back end
// and the queues between them. Uses ihex_pkg, ihex_front and ihex_back.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one ASCII character per word and sustains one character per clock
// cycle while full is low. It skips everything until a colon, then reads the byte
// count, address and type fields and the payload. Each data byte comes out as its own
// result word with the effective address (base plus record address plus byte index,
// wrapping at 32 bits); a done word follows the checksum. End-of-file records must
// carry a checksum of FF, extended linear address records load the upper 16 bits of
// the base, and start linear address records load the entry point. Segment records,
// byte counts above data_limit and non-hex characters inside a record produce an
// error word and send the parser back to hunting for a colon; record types above five
// are dropped silently. Checksums of other records are read but not checked. The front
// queue holds each character until the record state machine takes it, and the state
// machine then writes any result word into the result queue, from which it is popped.
// Both queues hold two words, so a short stall on either side does not stop the other;
// a longer stall on the result side fills both queues and raises full.
// data_limit resets to 255 and should be written only while the parser is idle.
module intel_hex_record_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output      logic        full,
	input  wire logic [7:0]  character,
	output      logic        empty,
	input  wire logic        pop,
	input  wire logic        cfg_write,
	input  wire logic [7:0]  cfg_data,
	output      logic [2:0]  kind,
	output      logic [7:0]  data_byte,
	output      logic [31:0] effective_address,
	output      logic [15:0] record_address,
	output      logic [7:0]  record_length,
	output      logic [7:0]  record_type,
	output      logic [31:0] current_base,
	output      logic [31:0] entry_address,
	output      logic [2:0]  error_code
);

	ihex_pkg::tok_t tok;
	ihex_pkg::res_t res;
	logic           tok_valid;
	logic           tok_ready;

	// Front end: classifies characters and queues them.
	ihex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.character (character),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);

	// Back end: walks the record fields and queues the results.
	ihex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign kind              = res.kind;
	assign data_byte         = res.data_byte;
	assign effective_address = res.effective_address;
	assign record_address    = res.record_address;
	assign record_length     = res.record_length;
	assign record_type       = res.record_type;
	assign current_base      = res.current_base;
	assign entry_address     = res.entry_address;
	assign error_code        = res.error_code;

	// An error word always carries a cause, and no other word carries one.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((kind == ihex_pkg::KIND_ERROR) == (error_code != ihex_pkg::ERR_NONE)))
		else $error("error code does not match result kind");

	// The base address only ever has its upper half loaded.
	a_base_low: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (current_base[15:0] == 16'd0))
		else $error("base address has nonzero low half");

	// Data bytes come only from data records with a nonzero byte count.
	a_data_rec: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == ihex_pkg::KIND_DATA) |->
			(record_type == ihex_pkg::REC_DATA && record_length != 8'd0))
		else $error("data byte from a record that cannot carry data");

	// Only data byte words carry a nonzero data byte.
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != ihex_pkg::KIND_DATA) |-> (data_byte == 8'd0))
		else $error("data byte set on a non-data result");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the Intel HEX record parser (intel_hex_record_parser).
// Depends on ihex_pkg for the result word type, kind, error and record type codes.
`timescale 1ns / 1ps

module tb;
	import ihex_pkg::*;

	// Record state of the parser as the scoreboard sees it. Where a record is in
	// its fields decides how many hex digits the next value takes.
	typedef enum logic [3:0] {
		P_SEEK,
		P_COUNT,
		P_ADDR,
		P_TYPE,
		P_DATA,
		P_BASE,
		P_ENTRY,
		P_SUM
	} rec_phase_t;

	// One directed case: a run of characters, an optional data_limit write before it,
	// and, where the answer is plain, the word that its last character must produce.
	typedef struct {
		string text;
		int    limit;
		bit    typed;
		res_t  want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  character;
	logic        empty;
	logic        pop;
	logic        cfg_write;
	logic [7:0]  cfg_data;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic [31:0] effective_address;
	logic [15:0] record_address;
	logic [7:0]  record_length;
	logic [7:0]  record_type;
	logic [31:0] current_base;
	logic [31:0] entry_address;
	logic [2:0]  error_code;

	intel_hex_record_parser u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.character         (character),
		.empty             (empty),
		.pop               (pop),
		.cfg_write         (cfg_write),
		.cfg_data          (cfg_data),
		.kind              (kind),
		.data_byte         (data_byte),
		.effective_address (effective_address),
		.record_address    (record_address),
		.record_length     (record_length),
		.record_type       (record_type),
		.current_base      (current_base),
		.entry_address     (entry_address),
		.error_code        (error_code)
	);

	// Decoder state mirrored from the parser's reset values.
	rec_phase_t  rec_phase = P_SEEK;
	int          digit_no  = 0;
	logic [31:0] acc_q     = '0;
	logic [7:0]  len_q     = '0;
	logic [15:0] addr_q    = '0;
	logic [7:0]  type_q    = '0;
	logic [7:0]  idx_q     = '0;
	logic [31:0] base_q    = '0;
	logic [31:0] start_q   = '0;
	logic [7:0]  limit_q   = 8'hff;

	// Result words that the parser still owes, oldest first.
	res_t        owed_words[$];

	int          errors       = 0;
	int          chars_sent   = 0;
	int          words_seen   = 0;
	int          bytes_seen   = 0;
	int          faults_seen  = 0;
	int          records_sent = 0;
	int          limit_writes = 0;
	bit          idle_on      = 1'b1;
	int          bad_countdown = -1;

	// Directed cases. They run from reset with data_limit at 255; the typed words
	// follow from the fields of each record and whatever earlier rows left behind.
	dir_row_t dir_rows [18] = '{
		// Noise while hunting produces nothing.
		'{"zQ\t~ 9", -1, 1'b0, '0},
		// The smallest end-of-file record, checksum FF.
		'{":00000001FF", -1, 1'b1,
			res_t'{KIND_EOF, 8'h00, 32'h0, 16'h0, 8'h00, REC_EOF, 32'h0, 32'h0, ERR_NONE}},
		// Extended linear address with byte count, address and base at their top values.
		'{":FFFFFF04FFFF00", -1, 1'b1,
			res_t'{KIND_BASE, 8'h00, 32'hffff_ffff, 16'hffff, 8'hff, REC_ELA,
				32'hffff_0000, 32'h0, ERR_NONE}},
		// Start linear address of all ones.
		'{":04000005FFFFFFFF00", -1, 1'b1,
			res_t'{KIND_START, 8'h00, 32'hffff_0000, 16'h0000, 8'h04, REC_SLA,
				32'hffff_0000, 32'hffff_ffff, ERR_NONE}},
		// Two data bytes whose effective address wraps past the top of memory.
		'{":02FFFF00a55Aee", -1, 1'b0, '0},
		// Base back to zero.
		'{":020000040000FA", -1, 1'b1,
			res_t'{KIND_BASE, 8'h00, 32'h0, 16'h0000, 8'h02, REC_ELA, 32'h0,
				32'hffff_ffff, ERR_NONE}},
		// Data bytes at both extremes.
		'{":0212340000FF55", -1, 1'b0, '0},
		// A zero-length data record goes straight to its checksum.
		'{":00FFFE0000", -1, 1'b1,
			res_t'{KIND_DONE, 8'h00, 32'h0000_fffe, 16'hfffe, 8'h00, REC_DATA, 32'h0,
				32'hffff_ffff, ERR_NONE}},
		// End of file with a wrong checksum.
		'{":00000001FE", -1, 1'b1,
			res_t'{KIND_ERROR, 8'h00, 32'h0, 16'h0000, 8'h00, REC_EOF, 32'h0,
				32'hffff_ffff, ERR_EOF_SUM}},
		// Extended segment address is refused right after the type field.
		'{":02000002", -1, 1'b1,
			res_t'{KIND_ERROR, 8'h00, 32'h0, 16'h0000, 8'h02, REC_ESA, 32'h0,
				32'hffff_ffff, ERR_SEGMENT}},
		// The rest of that record is hunted over; then a start segment address.
		'{"1000:04123403", -1, 1'b1,
			res_t'{KIND_ERROR, 8'h00, 32'h0000_1234, 16'h1234, 8'h04, REC_SSA, 32'h0,
				32'hffff_ffff, ERR_SEGMENT}},
		// Unknown record types, the largest byte count among them, are dropped.
		'{":00000006:FF0000FF", -1, 1'b0, '0},
		// A bad hex digit inside the byte count.
		'{":0G", -1, 1'b1,
			res_t'{KIND_ERROR, 8'h00, 32'h0, 16'h0000, 8'hff, 8'hff, 32'h0,
				32'hffff_ffff, ERR_HEX}},
		// A colon inside a record is a bad digit too.
		'{":12:", -1, 1'b1,
			res_t'{KIND_ERROR, 8'h00, 32'h0, 16'h0000, 8'h12, 8'hff, 32'h0,
				32'hffff_ffff, ERR_HEX}},
		// With the limit at zero a one-byte data record is too long...
		'{":01ABCD00", 0, 1'b1,
			res_t'{KIND_ERROR, 8'h00, 32'h0000_abcd, 16'habcd, 8'h01, REC_DATA, 32'h0,
				32'hffff_ffff, ERR_LONG}},
		// ...but an empty one still passes.
		'{":00ABCD0000", -1, 1'b1,
			res_t'{KIND_DONE, 8'h00, 32'h0000_abcd, 16'habcd, 8'h00, REC_DATA, 32'h0,
				32'hffff_ffff, ERR_NONE}},
		// A byte count exactly at the limit.
		'{":01000100C33B", 1, 1'b0, '0},
		// Start address of zero.
		'{":0400000500000000F7", -1, 1'b1,
			res_t'{KIND_START, 8'h00, 32'h0, 16'h0000, 8'h04, REC_SLA, 32'h0, 32'h0,
				ERR_NONE}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int nibble_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
		return -1;
	endfunction

	// Builds a word from the current record fields and held addresses.
	function automatic res_t make_word(input logic [2:0] k, input logic [7:0] d,
			input logic [31:0] eff, input logic [2:0] code);
		res_t w;
		w.kind              = k;
		w.data_byte         = d;
		w.effective_address = eff;
		w.record_address    = addr_q;
		w.record_length     = len_q;
		w.record_type       = type_q;
		w.current_base      = base_q;
		w.entry_address     = start_q;
		w.error_code        = code;
		return w;
	endfunction

	// Every error drops the record and sends the decoder back to hunting.
	function automatic res_t abort_record(input logic [2:0] code);
		rec_phase = P_SEEK;
		digit_no  = 0;
		acc_q     = '0;
		return make_word(KIND_ERROR, 8'h00, base_q + {16'h0, addr_q}, code);
	endfunction

	// Advances the mirrored decoder by one character. Returns 1 when the character
	// produces a result word, which is then left in w.
	function automatic bit decode_char(input logic [7:0] c, output res_t w);
		int          nib;
		int          need;
		logic [31:0] v;
		w = '0;
		if (rec_phase == P_SEEK) begin
			if (c == CHAR_COLON) begin
				rec_phase = P_COUNT;
				digit_no  = 0;
				acc_q     = '0;
			end
			return 1'b0;
		end
		nib = nibble_value(c);
		if (nib < 0) begin
			w = abort_record(ERR_HEX);
			return 1'b1;
		end
		acc_q = {acc_q[27:0], nib[3:0]};
		case (rec_phase)
			P_ADDR, P_BASE: need = 4;
			P_ENTRY:        need = 8;
			default:        need = 2;
		endcase
		if (digit_no + 1 < need) begin
			digit_no++;
			return 1'b0;
		end
		v        = acc_q;
		digit_no = 0;
		acc_q    = '0;
		case (rec_phase)
			P_COUNT: begin
				len_q     = v[7:0];
				rec_phase = P_ADDR;
				return 1'b0;
			end
			P_ADDR: begin
				addr_q    = v[15:0];
				rec_phase = P_TYPE;
				return 1'b0;
			end
			P_TYPE: begin
				type_q = v[7:0];
				idx_q  = '0;
				case (type_q)
					REC_DATA: begin
						if (len_q > limit_q) begin
							w = abort_record(ERR_LONG);
							return 1'b1;
						end
						rec_phase = (len_q != 8'h00) ? P_DATA : P_SUM;
					end
					REC_EOF:          rec_phase = P_SUM;
					REC_ESA, REC_SSA: begin
						w = abort_record(ERR_SEGMENT);
						return 1'b1;
					end
					REC_ELA:          rec_phase = P_BASE;
					REC_SLA:          rec_phase = P_ENTRY;
					default:          rec_phase = P_SEEK;
				endcase
				return 1'b0;
			end
			P_DATA: begin
				w = make_word(KIND_DATA, v[7:0], base_q + {16'h0, addr_q} + {24'h0, idx_q},
					ERR_NONE);
				idx_q = idx_q + 8'd1;
				if (idx_q == len_q) rec_phase = P_SUM;
				return 1'b1;
			end
			P_BASE: begin
				base_q    = {v[15:0], 16'h0000};
				rec_phase = P_SUM;
				return 1'b0;
			end
			P_ENTRY: begin
				start_q   = v;
				rec_phase = P_SUM;
				return 1'b0;
			end
			default: begin
				// Checksum field: only end-of-file records look at its value.
				rec_phase = P_SEEK;
				case (type_q)
					REC_DATA: w = make_word(KIND_DONE, 8'h00, base_q + {16'h0, addr_q},
						ERR_NONE);
					REC_EOF: begin
						if (v[7:0] == EOF_SUM)
							w = make_word(KIND_EOF, 8'h00, base_q + {16'h0, addr_q},
								ERR_NONE);
						else
							w = abort_record(ERR_EOF_SUM);
					end
					REC_ELA: w = make_word(KIND_BASE, 8'h00, base_q + {16'h0, addr_q},
						ERR_NONE);
					default: w = make_word(KIND_START, 8'h00, base_q + {16'h0, addr_q},
						ERR_NONE);
				endcase
				return 1'b1;
			end
		endcase
	endfunction

	// Gap length for either side: mostly none, sometimes short, rarely long; none while idling is off.
	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + {4'h0, n};
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (nibble_value(c) >= 0);
		return c;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Presents one character and holds it until the parser takes it. The expected
	// word, if any, is queued at the edge of acceptance; a directed row may supply
	// the word itself in place of the computed one.
	task automatic send_char(input logic [7:0] c, input bit use_want = 1'b0,
			input res_t want = '0);
		res_t w;
		bit   hit;
		int   gap;
		push      <= 1'b1;
		character <= c;
		do @(posedge clk); while (full);
		hit = decode_char(c, w);
		if (use_want) owed_words.push_back(want);
		else if (hit) owed_words.push_back(w);
		chars_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One hex digit of a record; the scheduled corruption, if any, replaces it.
	task automatic send_digit(input logic [3:0] n);
		logic [7:0] c;
		c = (bad_countdown == 0) ? non_hex() : hex_char(n);
		if (bad_countdown >= 0) bad_countdown--;
		send_char(c);
	endtask

	task automatic send_hex(input logic [31:0] v, input int nd);
		for (int i = nd - 1; i >= 0; i--) send_digit(v[4 * i +: 4]);
	endtask

	// One random record with some leading noise. A negative forced length picks a
	// record type and byte count at random.
	task automatic send_record(input int force_len);
		int          pick;
		int          len_v;
		logic [7:0]  rtype;
		logic [15:0] addr_v;
		repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)));
		pick   = $urandom_range(0, 99);
		addr_v = 16'($urandom);
		if (force_len >= 0 || pick < 62) rtype = REC_DATA;
		else if (pick < 70) rtype = REC_EOF;
		else if (pick < 78) rtype = REC_ELA;
		else if (pick < 86) rtype = REC_SLA;
		else if (pick < 90) rtype = $urandom_range(0, 1) ? REC_ESA : REC_SSA;
		else rtype = 8'($urandom_range(6, 255));
		case (rtype)
			REC_DATA: begin
				if (force_len >= 0) len_v = force_len;
				else if ($urandom_range(0, 49) == 0) len_v = $urandom_range(100, 255);
				else len_v = $urandom_range(0, 12);
			end
			REC_EOF: len_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
			REC_ELA: len_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 2;
			REC_SLA: len_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 4;
			default: len_v = $urandom_range(0, 255);
		endcase
		// About one record in twenty gets a broken character somewhere in it.
		bad_countdown = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 9 + 2 * len_v) : -1;
		send_char(CHAR_COLON);
		send_hex(32'(len_v), 2);
		send_hex(32'(addr_v), 4);
		send_hex(32'(rtype), 2);
		case (rtype)
			REC_DATA: repeat (len_v) send_hex($urandom, 2);
			REC_ELA:  send_hex($urandom, 4);
			REC_SLA:  send_hex($urandom, 8);
			default:  ;
		endcase
		if (rtype == REC_EOF && $urandom_range(0, 4) != 0) send_hex(32'(EOF_SUM), 2);
		else send_hex($urandom, 2);
		bad_countdown = -1;
		records_sent++;
	endtask

	// Stops sending and waits until every owed word has come out. Characters that
	// give no word can still sit in the front queue, so the task keeps waiting after
	// the last owed word before the parser counts as idle.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (owed_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		settle();
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		limit_q = v;
		limit_writes++;
	endtask

	// Result side: pops with random stalls and checks every word taken against the
	// oldest owed word.
	initial begin
		int   stall;
		res_t w;
		stall = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (owed_words.size() == 0) begin
					$error("unexpected result word: kind %0d, address %0h", kind,
						effective_address);
					errors++;
				end else begin
					w = owed_words.pop_front();
					check_field("kind", w.kind, kind);
					check_field("data_byte", w.data_byte, data_byte);
					check_field("effective_address", w.effective_address, effective_address);
					check_field("record_address", w.record_address, record_address);
					check_field("record_length", w.record_length, record_length);
					check_field("record_type", w.record_type, record_type);
					check_field("current_base", w.current_base, current_base);
					check_field("entry_address", w.entry_address, entry_address);
					check_field("error_code", w.error_code, error_code);
				end
				words_seen++;
				if (kind == KIND_DATA) bytes_seen++;
				if (kind == KIND_ERROR) faults_seen++;
			end
			if (stall == 0) stall = pick_gap();
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Character side: reset, the directed rows, then six phases of random records,
	// each under its own data_limit. One phase runs with no idling on either side.
	initial begin
		int         target;
		logic [7:0] lim;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		character <= '0;
		cfg_write <= 1'b0;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].limit >= 0) write_limit(8'(dir_rows[r].limit));
			for (int i = 0; i < dir_rows[r].text.len(); i++)
				send_char(dir_rows[r].text[i],
					dir_rows[r].typed && i == dir_rows[r].text.len() - 1, dir_rows[r].want);
		end

		for (int p = 0; p < 6; p++) begin
			case (p)
				0:       lim = 8'hff;
				1:       lim = 8'h00;
				3:       lim = 8'h01;
				4:       lim = 8'h10;
				default: lim = 8'($urandom_range(0, 255));
			endcase
			write_limit(lim);
			idle_on = (p != 2);
			// The first phase opens with a full-length data record at the top limit.
			if (p == 0) send_record(255);
			target = chars_sent + 75;
			while (chars_sent < target) send_record(-1);
		end

		settle();
		$display("Sent %0d characters in %0d directed rows and %0d random records, %0d limits.",
			chars_sent, $size(dir_rows), records_sent, limit_writes);
		$display("Checked %0d result words, %0d of them data bytes and %0d error reports.",
			words_seen, bytes_seen, faults_seen);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
